// ===== hw/rtl/cast_pkg.sv =====
package cast_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_HOUR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_MINUTE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_TIMEOUT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNOOZE_MINUTES = 2'd3;

    localparam logic [4:0] ALARM_HOUR_RESET     = 5'd0;
    localparam logic [5:0] ALARM_MINUTE_RESET   = 6'd1;
    localparam logic [6:0] ALARM_TIMEOUT_RESET  = 7'd60;
    localparam logic [8:0] SNOOZE_MINUTES_RESET = 9'd300;

    localparam logic [1:0] WATCH_HOLD = 2'd0;
    localparam logic [1:0] WATCH_RUN  = 2'd1;
    localparam logic [1:0] WATCH_LAP  = 2'd2;
    localparam logic [1:0] WATCH_ZERO = 2'd3;

    localparam logic [6:0] CENTIS_PER_SEC     = 7'd100;
    localparam logic [5:0] SECS_PER_MIN       = 6'd60;
    localparam logic [5:0] MINS_PER_HOUR      = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
    localparam logic [6:0] WATCH_MINUTES_WRAP = 7'd99;

    typedef struct packed {
        logic [1:0] stopwatch_mode;
        logic       snooze_start;
    } in_item_t;

    typedef struct packed {
        logic [6:0] clock_centis;
        logic [5:0] clock_seconds;
        logic [5:0] clock_minutes;
        logic [4:0] clock_hours;
        logic       alarm_active;
        logic       hour_chime;
        logic       day_advance;
        logic [6:0] watch_centis;
        logic [5:0] watch_seconds;
        logic [6:0] watch_minutes;
    } out_item_t;

endpackage

// ===== hw/rtl/clock_alarm_stopwatch_tick_core.sv =====
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data    (cast_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data   (cast_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one tick per cycle while in_ready is high; its result is in the output register the cycle after acceptance
// the rate is set by the combinational clock, alarm and stopwatch update logic
// in_ready drops only while the output register holds a result that is not taken
// cfg_ready is always high; writes take effect for the next accepted tick
// rst_n clears time, alarm, snooze and stopwatch state and loads register defaults
module clock_alarm_stopwatch_tick_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cast_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cast_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cast_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cast_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [4:0] alarm_hour_reg;
    logic [5:0] alarm_minute_reg;
    logic [6:0] alarm_timeout_reg;
    logic [8:0] snooze_minutes_reg;

    logic [6:0] time_centis_reg,        time_centis_next;
    logic [5:0] time_seconds_reg,       time_seconds_next;
    logic [5:0] time_minutes_reg,       time_minutes_next;
    logic [4:0] time_hours_reg,         time_hours_next;
    logic       alarm_flag_reg,         alarm_flag_next;
    logic [6:0] alarm_minute_count_reg, alarm_minute_count_next;
    logic       snooze_flag_reg,        snooze_flag_next;
    logic [8:0] snooze_count_reg,       snooze_count_next;
    logic [6:0] lap_centis_reg,         lap_centis_next;
    logic [5:0] lap_seconds_reg,        lap_seconds_next;
    logic [6:0] lap_minutes_reg,        lap_minutes_next;

    logic       chime_next;
    logic       day_next;

    logic                out_valid_reg;
    cast_pkg::out_item_t out_data_reg;
    cast_pkg::out_item_t out_data_next;

    logic in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hour_reg     <= cast_pkg::ALARM_HOUR_RESET;
            alarm_minute_reg   <= cast_pkg::ALARM_MINUTE_RESET;
            alarm_timeout_reg  <= cast_pkg::ALARM_TIMEOUT_RESET;
            snooze_minutes_reg <= cast_pkg::SNOOZE_MINUTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cast_pkg::CFG_ALARM_HOUR:     alarm_hour_reg     <= cfg_data[4:0];
                cast_pkg::CFG_ALARM_MINUTE:   alarm_minute_reg   <= cfg_data[5:0];
                cast_pkg::CFG_ALARM_TIMEOUT:  alarm_timeout_reg  <= cfg_data[6:0];
                cast_pkg::CFG_SNOOZE_MINUTES: snooze_minutes_reg <= cfg_data[8:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0] alarm_inc;
        logic [9:0] snooze_inc;
        logic       minute_roll;

        time_centis_next        = time_centis_reg;
        time_seconds_next       = time_seconds_reg;
        time_minutes_next       = time_minutes_reg;
        time_hours_next         = time_hours_reg;
        alarm_flag_next         = alarm_flag_reg;
        alarm_minute_count_next = alarm_minute_count_reg;
        snooze_flag_next        = snooze_flag_reg;
        snooze_count_next       = snooze_count_reg;
        lap_centis_next         = lap_centis_reg;
        lap_seconds_next        = lap_seconds_reg;
        lap_minutes_next        = lap_minutes_reg;
        chime_next              = 1'b0;
        day_next                = 1'b0;
        minute_roll             = 1'b0;

        if (in_data.snooze_start)
        begin
            alarm_flag_next         = 1'b0;
            alarm_minute_count_next = '0;
            snooze_flag_next        = 1'b1;
            snooze_count_next       = '0;
        end

        if (time_hours_reg == alarm_hour_reg && time_minutes_reg == alarm_minute_reg)
        begin
            alarm_flag_next = 1'b1;
        end

        // time of day
        time_centis_next = time_centis_reg + 7'd1;
        if (time_centis_next >= cast_pkg::CENTIS_PER_SEC)
        begin
            time_centis_next  = '0;
            time_seconds_next = time_seconds_reg + 6'd1;
            if (time_seconds_next >= cast_pkg::SECS_PER_MIN)
            begin
                minute_roll       = 1'b1;
                time_seconds_next = '0;
                time_minutes_next = time_minutes_reg + 6'd1;
                if (time_minutes_next >= cast_pkg::MINS_PER_HOUR)
                begin
                    time_minutes_next = '0;
                    time_hours_next   = time_hours_reg + 5'd1;
                    chime_next        = 1'b1;
                    if (time_hours_next >= cast_pkg::HOURS_PER_DAY)
                    begin
                        time_hours_next = '0;
                        day_next        = 1'b1;
                    end
                end
            end
        end

        // alarm timeout and snooze countdown
        alarm_inc  = {1'b0, alarm_minute_count_next} + 8'd1;
        snooze_inc = {1'b0, snooze_count_next} + 10'd1;
        if (minute_roll)
        begin
            if (alarm_flag_next)
            begin
                if (alarm_inc > {1'b0, alarm_timeout_reg})
                begin
                    alarm_flag_next         = 1'b0;
                    alarm_minute_count_next = '0;
                end
                else
                begin
                    alarm_minute_count_next = alarm_inc[6:0];
                end
            end
            if (snooze_flag_next)
            begin
                if (snooze_inc > {1'b0, snooze_minutes_reg})
                begin
                    alarm_flag_next   = 1'b1;
                    snooze_flag_next  = 1'b0;
                    snooze_count_next = '0;
                end
                else
                begin
                    snooze_count_next = snooze_inc[8:0];
                end
            end
        end

        // stopwatch
        case (in_data.stopwatch_mode) inside
            cast_pkg::WATCH_RUN, cast_pkg::WATCH_LAP:
            begin
                lap_centis_next = lap_centis_reg + 7'd1;
            end
            cast_pkg::WATCH_ZERO:
            begin
                lap_centis_next  = '0;
                lap_seconds_next = '0;
                lap_minutes_next = '0;
            end
            default:
            begin
            end
        endcase
        if (lap_centis_next >= cast_pkg::CENTIS_PER_SEC)
        begin
            lap_centis_next  = '0;
            lap_seconds_next = lap_seconds_reg + 6'd1;
            if (lap_seconds_next >= cast_pkg::SECS_PER_MIN)
            begin
                lap_seconds_next = '0;
                lap_minutes_next = lap_minutes_reg + 7'd1;
                if (lap_minutes_next >= cast_pkg::WATCH_MINUTES_WRAP)
                begin
                    lap_minutes_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_data_next.clock_centis  = time_centis_next;
        out_data_next.clock_seconds = time_seconds_next;
        out_data_next.clock_minutes = time_minutes_next;
        out_data_next.clock_hours   = time_hours_next;
        out_data_next.alarm_active  = alarm_flag_next;
        out_data_next.hour_chime    = chime_next;
        out_data_next.day_advance   = day_next;
        out_data_next.watch_centis  = lap_centis_next;
        out_data_next.watch_seconds = lap_seconds_next;
        out_data_next.watch_minutes = lap_minutes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_centis_reg        <= '0;
            time_seconds_reg       <= '0;
            time_minutes_reg       <= '0;
            time_hours_reg         <= '0;
            alarm_flag_reg         <= 1'b0;
            alarm_minute_count_reg <= '0;
            snooze_flag_reg        <= 1'b0;
            snooze_count_reg       <= '0;
            lap_centis_reg         <= '0;
            lap_seconds_reg        <= '0;
            lap_minutes_reg        <= '0;
        end
        else if (in_accept)
        begin
            time_centis_reg        <= time_centis_next;
            time_seconds_reg       <= time_seconds_next;
            time_minutes_reg       <= time_minutes_next;
            time_hours_reg         <= time_hours_next;
            alarm_flag_reg         <= alarm_flag_next;
            alarm_minute_count_reg <= alarm_minute_count_next;
            snooze_flag_reg        <= snooze_flag_next;
            snooze_count_reg       <= snooze_count_next;
            lap_centis_reg         <= lap_centis_next;
            lap_seconds_reg        <= lap_seconds_next;
            lap_minutes_reg        <= lap_minutes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted tick produced no result");

    a_day_implies_chime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.day_advance || out_data.hour_chime))
        else $error("day advance without hour chime");

    a_chime_at_top_of_hour: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hour_chime) |->
        (out_data.clock_minutes == '0 && out_data.clock_seconds == '0 &&
         out_data.clock_centis == '0))
        else $error("hour chime away from the top of the hour");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_centis_reg < cast_pkg::CENTIS_PER_SEC && time_seconds_reg < cast_pkg::SECS_PER_MIN &&
        time_minutes_reg < cast_pkg::MINS_PER_HOUR && time_hours_reg < cast_pkg::HOURS_PER_DAY)
        else $error("time of day out of range");

    a_snooze_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.snooze_start) |=> (snooze_flag_reg || alarm_flag_reg))
        else $error("snooze request lost");
`endif

endmodule

// ===== tb/clock_alarm_stopwatch_tick_core_tb.sv =====
module clock_alarm_stopwatch_tick_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class clock_tracker;
        logic [4:0] alarm_hour    = cast_pkg::ALARM_HOUR_RESET;
        logic [5:0] alarm_minute  = cast_pkg::ALARM_MINUTE_RESET;
        logic [6:0] alarm_timeout = cast_pkg::ALARM_TIMEOUT_RESET;
        logic [8:0] snooze_limit  = cast_pkg::SNOOZE_MINUTES_RESET;

        logic [6:0] centis       = '0;
        logic [5:0] seconds      = '0;
        logic [5:0] minutes      = '0;
        logic [4:0] hours        = '0;
        logic       alarm_on     = 1'b0;
        logic [6:0] alarm_count  = '0;
        logic       snoozing     = 1'b0;
        logic [8:0] snooze_count = '0;
        logic [6:0] sw_centis    = '0;
        logic [5:0] sw_seconds   = '0;
        logic [6:0] sw_minutes   = '0;

        cast_pkg::out_item_t expected_readouts[$];
        int unsigned         mismatches = 0;

        function void write_reg(logic [cast_pkg::CFG_INDEX_W-1:0] idx,
                                logic [cast_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                cast_pkg::CFG_ALARM_HOUR:     alarm_hour    = value[4:0];
                cast_pkg::CFG_ALARM_MINUTE:   alarm_minute  = value[5:0];
                cast_pkg::CFG_ALARM_TIMEOUT:  alarm_timeout = value[6:0];
                cast_pkg::CFG_SNOOZE_MINUTES: snooze_limit  = value[8:0];
                default:                      ;
            endcase
        endfunction

        function void minute_rolled();
            if (alarm_on)
            begin
                if (int'(alarm_count) + 1 > int'(alarm_timeout))
                begin
                    alarm_on    = 1'b0;
                    alarm_count = '0;
                end
                else
                    alarm_count = alarm_count + 7'd1;
            end
            if (snoozing)
            begin
                if (int'(snooze_count) + 1 > int'(snooze_limit))
                begin
                    alarm_on     = 1'b1;
                    snoozing     = 1'b0;
                    snooze_count = '0;
                end
                else
                    snooze_count = snooze_count + 9'd1;
            end
        endfunction

        function cast_pkg::out_item_t advance_tick(cast_pkg::in_item_t tick);
            cast_pkg::out_item_t r;
            logic                chime;
            logic                day;
            chime = 1'b0;
            day   = 1'b0;
            if (tick.snooze_start)
            begin
                alarm_on     = 1'b0;
                alarm_count  = '0;
                snoozing     = 1'b1;
                snooze_count = '0;
            end
            if (hours == alarm_hour && minutes == alarm_minute)
                alarm_on = 1'b1;

            centis = centis + 7'd1;
            if (centis >= cast_pkg::CENTIS_PER_SEC)
            begin
                centis  = '0;
                seconds = seconds + 6'd1;
                if (seconds >= cast_pkg::SECS_PER_MIN)
                begin
                    minute_rolled();
                    seconds = '0;
                    minutes = minutes + 6'd1;
                    if (minutes >= cast_pkg::MINS_PER_HOUR)
                    begin
                        minutes = '0;
                        hours   = hours + 5'd1;
                        chime   = 1'b1;
                        if (hours >= cast_pkg::HOURS_PER_DAY)
                        begin
                            hours = '0;
                            day   = 1'b1;
                        end
                    end
                end
            end

            if (tick.stopwatch_mode == cast_pkg::WATCH_RUN ||
                tick.stopwatch_mode == cast_pkg::WATCH_LAP)
                sw_centis = sw_centis + 7'd1;
            else if (tick.stopwatch_mode == cast_pkg::WATCH_ZERO)
            begin
                sw_centis  = '0;
                sw_seconds = '0;
                sw_minutes = '0;
            end
            if (sw_centis >= cast_pkg::CENTIS_PER_SEC)
            begin
                sw_centis  = '0;
                sw_seconds = sw_seconds + 6'd1;
                if (sw_seconds >= cast_pkg::SECS_PER_MIN)
                begin
                    sw_seconds = '0;
                    sw_minutes = sw_minutes + 7'd1;
                    if (sw_minutes >= cast_pkg::WATCH_MINUTES_WRAP)
                        sw_minutes = '0;
                end
            end

            r.clock_centis  = centis;
            r.clock_seconds = seconds;
            r.clock_minutes = minutes;
            r.clock_hours   = hours;
            r.alarm_active  = alarm_on;
            r.hour_chime    = chime;
            r.day_advance   = day;
            r.watch_centis  = sw_centis;
            r.watch_seconds = sw_seconds;
            r.watch_minutes = sw_minutes;
            return r;
        endfunction

        function void note_tick(cast_pkg::in_item_t tick);
            expected_readouts.push_back(advance_tick(tick));
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_readout(cast_pkg::out_item_t got);
            cast_pkg::out_item_t want;
            if (expected_readouts.size() == 0)
            begin
                mismatches++;
                $display("%0t readout with nothing expected: expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_readouts.pop_front();
            compare("clock_centis", want.clock_centis, got.clock_centis);
            compare("clock_seconds", want.clock_seconds, got.clock_seconds);
            compare("clock_minutes", want.clock_minutes, got.clock_minutes);
            compare("clock_hours", want.clock_hours, got.clock_hours);
            compare("alarm_active", want.alarm_active, got.alarm_active);
            compare("hour_chime", want.hour_chime, got.hour_chime);
            compare("day_advance", want.day_advance, got.day_advance);
            compare("watch_centis", want.watch_centis, got.watch_centis);
            compare("watch_seconds", want.watch_seconds, got.watch_seconds);
            compare("watch_minutes", want.watch_minutes, got.watch_minutes);
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    cast_pkg::in_item_t               in_data;
    logic                             out_valid;
    logic                             out_ready;
    cast_pkg::out_item_t              out_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [cast_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cast_pkg::CFG_DATA_W-1:0]  cfg_data;

    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    bit           rx_hold_request;
    clock_tracker tracker;

    clock_alarm_stopwatch_tick_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side, with an occasional long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request)
            begin
                hold_left       = 400;
                rx_hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                tracker.note_tick(in_data);
            if (out_valid && out_ready)
                tracker.check_readout(out_data);
        end
    end

    task automatic put_reg(input logic [cast_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cast_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_alarm(input logic [4:0] hour, input logic [5:0] minute,
                             input logic [6:0] timeout, input logic [8:0] snooze);
        put_reg(cast_pkg::CFG_ALARM_HOUR, cast_pkg::CFG_DATA_W'(hour));
        put_reg(cast_pkg::CFG_ALARM_MINUTE, cast_pkg::CFG_DATA_W'(minute));
        put_reg(cast_pkg::CFG_ALARM_TIMEOUT, cast_pkg::CFG_DATA_W'(timeout));
        put_reg(cast_pkg::CFG_SNOOZE_MINUTES, snooze);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input cast_pkg::in_item_t tick);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic run_ticks(input int unsigned count, input int unsigned snooze_odds,
                             input bit watch_steady);
        cast_pkg::in_item_t tick;
        repeat (count)
        begin
            tick.snooze_start = ($urandom_range(snooze_odds - 1) == 0);
            if (!watch_steady)
                tick.stopwatch_mode = 2'($urandom_range(3));
            else if ($urandom_range(999) == 0)
                tick.stopwatch_mode = cast_pkg::WATCH_HOLD;
            else
                tick.stopwatch_mode = $urandom_range(1) ? cast_pkg::WATCH_LAP
                                                        : cast_pkg::WATCH_RUN;
            send_tick(tick);
        end
    endtask

    // stop sending and wait for every pending readout
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        cast_pkg::in_item_t tick;
        tracker         = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        out_ready       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rx_hold_request = 1'b0;
        tx_idle_pct     = 12;
        rx_idle_pct     = 75;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every stopwatch mode, snooze requests mixed in
        for (int i = 0; i < 20; i++)
        begin
            tick.stopwatch_mode = 2'(i % 4);
            tick.snooze_start   = (i % 7 == 6) || (i == 19);
            send_tick(tick);
        end
        settle();

        // alarm matches right away, short timeout and snooze
        set_alarm(5'd0, 6'd0, 7'd1, 9'd1);
        rx_hold_request = 1'b1;
        run_ticks(700, 50, 1'b0);
        settle();

        tx_idle_pct = 75;
        rx_idle_pct = 12;
        set_alarm(5'd23, 6'd59, 7'd0, 9'd0);
        run_ticks(500, 16, 1'b0);
        settle();

        // alarm time that can never match
        set_alarm(5'd31, 6'd63, 7'd127, 9'd511);
        run_ticks(250, 8, 1'b0);
        settle();

        // no random idling but one long result hold-off, stopwatch mostly running
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_alarm(5'd0, 6'd5, 7'd3, 9'd2);
        rx_hold_request = 1'b1;
        run_ticks(280, 100, 1'b1);
        settle();

        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_readouts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
